[sv/kalt_pkg.sv]
`timescale 1ns / 1ps
package kalt_pkg;
	localparam int TableSlotsDef = 1024;
	localparam int ListLimitDef = 16;

	localparam logic [2:0] ST_APPEND     = 3'd0;
	localparam logic [2:0] ST_NEW        = 3'd1;
	localparam logic [2:0] ST_LIST_FULL  = 3'd2;
	localparam logic [2:0] ST_TABLE_FULL = 3'd3;
	localparam logic [2:0] ST_CLEARED    = 3'd4;

	localparam logic CMD_INSERT = 1'b0;
	localparam logic CMD_CLEAR  = 1'b1;

	typedef struct packed {
		logic        command;
		logic [31:0] key_first;
		logic [31:0] key_second;
		logic [31:0] entry_id;
		logic [15:0] entry_length;
	} in_word_t;

	typedef struct packed {
		logic [2:0] status;
		logic [9:0] key_slot;
		logic [3:0] list_position;
		logic [4:0] list_count;
	} out_word_t;

	// Classified item handed from front to back: full 32-bit hash, not yet
	// reduced to a slot.
	typedef struct packed {
		logic        command;
		logic [63:0] key;
		logic [31:0] hash;
		logic [31:0] entry_id;
		logic [15:0] entry_length;
	} job_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_READ,
		BK_CHECK,
		BK_CLEAR,
		BK_EMIT
	} bk_state_t;

	typedef enum logic [1:0] {
		FR_IDLE,
		FR_MUL2,
		FR_DONE
	} fr_state_t;
endpackage

[sv/kalt_if.sv]
`timescale 1ns / 1ps
interface kalt_if #(parameter int W = 8);
	logic         valid;
	logic         ready;
	logic [W-1:0] data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

[sv/kalt_front.sv]
`timescale 1ns / 1ps
// Accepts words and computes the hash in two multiplier steps.
module kalt_front (
	input  logic           clk,
	input  logic           arst_n,
	kalt_if.sink           in_ch,
	output logic           job_valid,
	output kalt_pkg::job_t job,
	input  logic           job_ready
);
	import kalt_pkg::*;

	fr_state_t   state_q, state_d;
	in_word_t    w_q;
	logic [31:0] x_q;
	logic [31:0] x1, x2;

	assign x1 = (w_q.key_first * 32'h9E3779B1) ^ w_q.key_second;
	assign x2 = x_q * 32'h85EBCA6B;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= FR_IDLE;
		else state_q <= state_d;
	end

	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) w_q <= in_word_t'(in_ch.data);
		if (state_q == FR_IDLE && !in_ch.ready) x_q <= x1 ^ (x1 >> 16);
		else if (state_q == FR_MUL2) x_q <= x2 ^ (x2 >> 13);
	end

	// idle holds the captured word for the first hash step: ready low then
	logic have_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) have_q <= 1'b0;
		else if (in_ch.valid && in_ch.ready) have_q <= 1'b1;
		else if (state_q == FR_IDLE && have_q) have_q <= 1'b0;
	end

	always_comb begin
		state_d     = state_q;
		in_ch.ready = 1'b0;
		job_valid   = 1'b0;
		unique case (state_q)
			FR_IDLE: begin
				in_ch.ready = !have_q;
				if (have_q) state_d = FR_MUL2;
			end
			FR_MUL2: state_d = FR_DONE;
			FR_DONE: begin
				job_valid = 1'b1;
				if (job_ready) state_d = FR_IDLE;
			end
			default: state_d = FR_IDLE;
		endcase
	end

	assign job.command      = w_q.command;
	assign job.key          = {w_q.key_first, w_q.key_second};
	assign job.hash         = x_q;
	assign job.entry_id     = w_q.entry_id;
	assign job.entry_length = w_q.entry_length;
endmodule

[sv/kalt_queue.sv]
`timescale 1ns / 1ps
// Two-entry queue between front and back.
module kalt_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           wr_valid,
	input  kalt_pkg::job_t wr_job,
	output logic           wr_ready,
	output logic           rd_valid,
	output kalt_pkg::job_t rd_job,
	input  logic           rd_ready
);
	import kalt_pkg::*;

	job_t       mem_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;
	logic       wr, rd;

	assign wr_ready = cnt_q != 2'd2;
	assign rd_valid = cnt_q != 2'd0;
	assign rd_job   = mem_q[rp_q];
	assign wr       = wr_valid && wr_ready;
	assign rd       = rd_valid && rd_ready;

	always_ff @(posedge clk) if (wr) mem_q[wp_q] <= wr_job;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (wr) wp_q <= !wp_q;
			if (rd) rp_q <= !rp_q;
			cnt_q <= cnt_q + 2'(wr) - 2'(rd);
		end
	end
endmodule

[sv/kalt_back.sv]
`timescale 1ns / 1ps
// Probe sequencer: slot memory read per probe, list memory write on append/new.
module kalt_back #(
	parameter int TABLE_SLOTS = kalt_pkg::TableSlotsDef,
	parameter int LIST_LIMIT  = kalt_pkg::ListLimitDef
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           job_valid,
	input  kalt_pkg::job_t job,
	output logic           job_ready,
	kalt_if.source         out_ch
);
	import kalt_pkg::*;

	localparam int SW = $clog2(TABLE_SLOTS);
	localparam int LW = $clog2(LIST_LIMIT + 1);
	localparam int PW = (LIST_LIMIT > 1) ? $clog2(LIST_LIMIT) : 1;
	localparam int AW = SW + PW;
	localparam bit POW2 = (TABLE_SLOTS & (TABLE_SLOTS - 1)) == 0;

	// reciprocal for hash mod slots: ceil(2^(32+SW) / TABLE_SLOTS), 33 bits
	localparam logic [64:0] RECIP = ((65'd1 << (32 + SW)) + 65'(TABLE_SLOTS) - 65'd1)
		/ 65'(TABLE_SLOTS);
	localparam logic [16:0] RECIP_HI = RECIP[32:16];
	localparam logic [15:0] RECIP_LO = RECIP[15:0];

	// valid bits via epoch marks: a slot is valid when its epoch equals current;
	// epochs run 1..255, mark 0 is never current
	localparam int EW = 8;

	bk_state_t state_q, state_d;
	job_t      job_q;
	logic [SW-1:0] slot_q;
	logic [SW:0]   probes_q;
	logic [31:0]   hrem_q;
	logic          hred_q;
	logic [64:0]   hacc_q;
	logic [1:0]    hstep_q;

	logic [63:0]    key_mem [TABLE_SLOTS];
	logic [LW-1:0]  cnt_mem [TABLE_SLOTS];
	logic [EW-1:0]  ep_mem  [TABLE_SLOTS];
	logic [31:0]    id_mem  [TABLE_SLOTS*LIST_LIMIT];
	logic [15:0]    len_mem [TABLE_SLOTS*LIST_LIMIT];

	logic [63:0]   rkey_q;
	logic [LW-1:0] rcnt_q;
	logic [EW-1:0] rep_q;
	logic [EW-1:0] epoch_q;
	logic [SW:0]   clr_q;
	logic          clr_run_q;

	out_word_t res_q, res_d;
	logic      ovalid_q;

	logic rd_en, key_we, cnt_we, ep_we, lst_we, ep_clr;
	logic [LW-1:0] cnt_wd;
	logic [PW-1:0] pos;
	logic [AW-1:0] lst_addr;
	logic [SW-1:0] ep_addr;
	logic          hit_valid;

	assign hit_valid = rep_q == epoch_q;
	// a new key starts its list at position 0
	assign pos       = hit_valid ? PW'(rcnt_q) : '0;
	assign lst_addr  = AW'(slot_q) * AW'(LIST_LIMIT) + AW'(pos);
	assign ep_addr   = ep_clr ? clr_q[SW-1:0] : slot_q;

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rkey_q <= key_mem[slot_q];
			rcnt_q <= cnt_mem[slot_q];
			rep_q  <= ep_mem[slot_q];
		end
		if (key_we) key_mem[slot_q] <= job_q.key;
		if (cnt_we) cnt_mem[slot_q] <= cnt_wd;
		if (ep_we || ep_clr) ep_mem[ep_addr] <= ep_clr ? '0 : epoch_q;
		if (lst_we) begin
			id_mem[lst_addr]  <= job_q.entry_id;
			len_mem[lst_addr] <= job_q.entry_length;
		end
		if (job_valid && job_ready) job_q <= job;
		if (state_d == BK_EMIT) res_q <= res_d;
	end

	// home = hash mod slots; for non-power-of-two, reciprocal multiply in steps
	// (two partial products, shift, multiply back and subtract)
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= BK_IDLE;
			ovalid_q  <= 1'b0;
			epoch_q   <= EW'(1);
			clr_q     <= '0;
			clr_run_q <= 1'b1;
			slot_q    <= '0;
			probes_q  <= '0;
			hrem_q    <= '0;
			hred_q    <= 1'b0;
			hacc_q    <= '0;
			hstep_q   <= '0;
		end else begin
			state_q <= state_d;
			if (clr_run_q) begin
				clr_q <= clr_q + 1'b1;
				if (clr_q == (SW+1)'(TABLE_SLOTS - 1)) clr_run_q <= 1'b0;
			end
			if (state_d == BK_EMIT) ovalid_q <= 1'b1;
			else if (out_ch.ready) ovalid_q <= 1'b0;
			if (state_q == BK_CLEAR) begin
				if (epoch_q == '1) begin
					clr_run_q <= 1'b1;
					clr_q     <= '0;
					epoch_q   <= EW'(1);
				end else begin
					epoch_q <= epoch_q + 1'b1;
				end
			end
			if (job_valid && job_ready) begin
				hred_q   <= 1'b1;
				hrem_q   <= job.hash;
				hstep_q  <= '0;
				probes_q <= '0;
			end else if (hred_q) begin
				if (POW2) begin
					slot_q <= hrem_q[SW-1:0];
					hred_q <= 1'b0;
				end else begin
					hstep_q <= hstep_q + 1'b1;
					unique case (hstep_q)
						2'd0: hacc_q <= {49'(hrem_q) * 49'(RECIP_HI), 16'd0};
						2'd1: hacc_q <= hacc_q + 65'(48'(hrem_q) * 48'(RECIP_LO));
						2'd2: hacc_q <= hacc_q >> (32 + SW);
						2'd3: begin
							slot_q <= SW'(hrem_q - hacc_q[31:0] * 32'(TABLE_SLOTS));
							hred_q <= 1'b0;
						end
					endcase
				end
			end else if (state_q == BK_CHECK && state_d == BK_READ) begin
				slot_q   <= (slot_q == SW'(TABLE_SLOTS - 1)) ? '0 : slot_q + 1'b1;
				probes_q <= probes_q + 1'b1;
			end
		end
	end

	always_comb begin
		state_d   = state_q;
		job_ready = 1'b0;
		rd_en = 1'b0; key_we = 1'b0; cnt_we = 1'b0; ep_we = 1'b0; lst_we = 1'b0;
		cnt_wd = '0;
		ep_clr = clr_run_q;
		res_d  = '0;
		unique case (state_q)
			BK_IDLE: begin
				job_ready = !clr_run_q && !ovalid_q;
				if (job_valid && job_ready)
					state_d = (job.command == CMD_CLEAR) ? BK_CLEAR : BK_READ;
			end
			BK_READ: begin
				if (!hred_q) begin
					rd_en   = 1'b1;
					state_d = BK_CHECK;
				end
			end
			BK_CHECK: begin
				if (probes_q == (SW+1)'(TABLE_SLOTS)) begin
					res_d.status = ST_TABLE_FULL;
					state_d = BK_EMIT;
				end else if (!hit_valid) begin
					key_we = 1'b1; cnt_we = 1'b1; ep_we = 1'b1; lst_we = 1'b1;
					cnt_wd = LW'(1);
					res_d.status     = ST_NEW;
					res_d.key_slot   = 10'(slot_q);
					res_d.list_count = 5'd1;
					state_d = BK_EMIT;
				end else if (rkey_q == job_q.key) begin
					res_d.key_slot = 10'(slot_q);
					if (rcnt_q < LW'(LIST_LIMIT)) begin
						cnt_we = 1'b1; lst_we = 1'b1;
						cnt_wd = rcnt_q + 1'b1;
						res_d.status        = ST_APPEND;
						res_d.list_position = 4'(rcnt_q);
						res_d.list_count    = 5'(cnt_wd);
					end else begin
						res_d.status     = ST_LIST_FULL;
						res_d.list_count = 5'(LIST_LIMIT);
					end
					state_d = BK_EMIT;
				end else begin
					state_d = BK_READ;
				end
			end
			BK_CLEAR: begin
				res_d.status = ST_CLEARED;
				state_d = BK_EMIT;
			end
			BK_EMIT: state_d = BK_IDLE;
			default: state_d = BK_IDLE;
		endcase
	end

	assign out_ch.valid = ovalid_q;
	assign out_ch.data  = res_q;
endmodule

[sv/keyed_append_list_table.sv]
`timescale 1ns / 1ps
// Keyed multimap store. Each insert word hashes its 64-bit key to a home
// slot and probes linearly until it finds the key or an unused slot; the
// pair is appended to that slot's list (up to LIST_LIMIT), a full list or a
// full table drops it with a status. A clear word empties the table by
// bumping an epoch mark; every 255th clear (and reset) starts a sweep of
// all TABLE_SLOTS slots rewriting the marks, during which the back takes no
// word from the queue. The front computes the hash with two multiplies, a
// two-entry queue decouples it from the back, which does a slot memory read
// per probe after a modulo step (a bit select when TABLE_SLOTS is a power of
// two, else a reciprocal multiply).
module keyed_append_list_table #(
	parameter int TABLE_SLOTS = kalt_pkg::TableSlotsDef,
	parameter int LIST_LIMIT  = kalt_pkg::ListLimitDef
) (
	input  logic clk,
	input  logic arst_n,
	kalt_if.sink   in_ch,
	kalt_if.source out_ch
);
	import kalt_pkg::*;

	logic f_valid, f_ready, b_valid, b_ready;
	job_t f_job, b_job;

	kalt_front u_front (
		.clk, .arst_n, .in_ch,
		.job_valid(f_valid), .job(f_job), .job_ready(f_ready)
	);

	kalt_queue u_queue (
		.clk, .arst_n,
		.wr_valid(f_valid), .wr_job(f_job), .wr_ready(f_ready),
		.rd_valid(b_valid), .rd_job(b_job), .rd_ready(b_ready)
	);

	kalt_back #(.TABLE_SLOTS(TABLE_SLOTS), .LIST_LIMIT(LIST_LIMIT)) u_back (
		.clk, .arst_n,
		.job_valid(b_valid), .job(b_job), .job_ready(b_ready),
		.out_ch
	);
endmodule
